// ===== design/rat_pkg.sv =====
// Package for the recurring alarm table: sizes, codes, wrap limits and transfer types.
package rat_pkg;

   localparam int ENTRIES = 16;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // action codes
   localparam logic [2:0] ACT_ADD     = 3'd0;
   localparam logic [2:0] ACT_ADD_RUN = 3'd1;
   localparam logic [2:0] ACT_REMOVE  = 3'd2;
   localparam logic [2:0] ACT_CLEAR   = 3'd3;
   localparam logic [2:0] ACT_TICK    = 3'd4;

   // alarm kinds
   localparam logic [1:0] KIND_DAILY    = 2'd0;
   localparam logic [1:0] KIND_HOURLY   = 2'd1;
   localparam logic [1:0] KIND_MINUTELY = 2'd2;
   localparam logic [1:0] KIND_MONTHLY  = 2'd3;

   // acknowledge status codes
   localparam logic [1:0] STAT_DONE = 2'd0;
   localparam logic [1:0] STAT_DUP  = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   // result kinds
   localparam logic RES_ACK   = 1'b0;
   localparam logic RES_FIRED = 1'b1;

   // wrap limits
   localparam logic [2:0] WDAY_LAST   = 3'd6;
   localparam logic [4:0] HOUR_LAST   = 5'd23;
   localparam logic [5:0] MINUTE_LAST = 6'd59;
   localparam logic [3:0] MONTH_LAST  = 4'd12;
   localparam logic [3:0] MONTH_FIRST = 4'd1;

   typedef struct packed {
      logic [2:0] action;
      logic       one_shot;
      logic [1:0] kind;
      logic [7:0] payload;
      logic [2:0] wday;
      logic [3:0] month_num;
      logic [4:0] hour_num;
      logic [5:0] minute_num;
      logic [5:0] second_num;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [1:0] status;
      logic [5:0] slot;
      logic [7:0] fired_payload;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       one_shot;
      logic [7:0] payload;
      logic [2:0] wday;
      logic [3:0] month;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } entry_type;

endpackage

// ===== design/recurring_alarm_table_core.sv =====
// Recurring alarm table: entry store; sequencer scans one slot per cycle when unstalled.
//
//  channel | ports                      | direction | moves
//  --------+----------------------------+-----------+------------------------------
//  request | req_valid req_stall req_data | in      | one action per transfer
//  result  | rsp_valid rsp_stall rsp_data | out     | fired entries, then one ack
//
// Reset empties the table at once (valid bits only). Each action, unused codes too, ends
// in one ack. An add seeks a twin and the lowest free slot, stores; add_and_run also
// scans for hits; tick scans for hits; remove drops payload matches; clear empties the
// table. The sequencer steps a single slot comparator across it; rsp_stall can hold it.
// req_stall is high from the transfer until the acknowledge enters the output register.
module recurring_alarm_table_core
   import rat_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DUP,
      S_STORE,
      S_SCAN,
      S_REMOVE,
      S_ACK
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     free_ff, free_in;
   logic                 free_found_ff, free_found_in;
   logic                 dup_ff, dup_in;
   logic [1:0]           status_ff, status_in;
   logic [5:0]           slot_ff, slot_in;
   req_type              item_ff, item_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   entry_type            entry_ff [ENTRIES];
   entry_type            entry_in [ENTRIES];
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   entry_type            cur;
   entry_type            adv;
   logic                 hit;
   logic                 out_free;
   logic                 idx_last;

   assign cur      = entry_ff[idx_ff];
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign idx_last = (idx_ff == IDX_W'(ENTRIES - 1));

   // match the current slot against the item's time and work out its advanced schedule
   always_comb begin
      adv = cur;
      hit = 1'b0;
      case (cur.kind)
         KIND_DAILY: begin
            hit = (cur.wday == item_ff.wday) && (cur.hour == item_ff.hour_num) &&
                  (cur.minute == item_ff.minute_num);
            adv.wday = (cur.wday >= WDAY_LAST) ? 3'd0 : cur.wday + 3'd1;
         end
         KIND_HOURLY: begin
            hit = (cur.hour == item_ff.hour_num) && (cur.minute == item_ff.minute_num);
            adv.hour = (cur.hour >= HOUR_LAST) ? 5'd0 : cur.hour + 5'd1;
         end
         KIND_MINUTELY: begin
            hit = (cur.minute == item_ff.minute_num);
            adv.minute = (cur.minute >= MINUTE_LAST) ? 6'd0 : cur.minute + 6'd1;
         end
         default: begin
            hit = (cur.month == item_ff.month_num) && (cur.hour == item_ff.hour_num) &&
                  (cur.minute == item_ff.minute_num);
            adv.month = (cur.month >= MONTH_LAST || cur.month == 4'd0) ?
                        MONTH_FIRST : cur.month + 4'd1;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      free_in       = free_ff;
      free_found_in = free_found_ff;
      dup_in        = dup_ff;
      status_in     = status_ff;
      slot_in       = slot_ff;
      item_in       = item_ff;
      valid_in      = valid_ff;
      entry_in      = entry_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in       = req_data;
               idx_in        = '0;
               free_in       = '0;
               free_found_in = 1'b0;
               dup_in        = 1'b0;
               status_in     = STAT_DONE;
               slot_in       = '0;
               case (req_data.action)
                  ACT_ADD, ACT_ADD_RUN: state_in = S_DUP;
                  ACT_REMOVE:           state_in = S_REMOVE;
                  ACT_CLEAR: begin
                     valid_in = '0;
                     state_in = S_ACK;
                  end
                  ACT_TICK:             state_in = S_SCAN;
                  default:              state_in = S_ACK;
               endcase
            end
         end
         S_DUP: begin
            // look for a twin and note the lowest free slot on the way
            if (valid_ff[idx_ff] && cur.payload == item_ff.payload &&
                cur.hour == item_ff.hour_num && cur.minute == item_ff.minute_num &&
                cur.second == item_ff.second_num && cur.wday == item_ff.wday) begin
               dup_in = 1'b1;
            end
            if (!valid_ff[idx_ff] && !free_found_ff) begin
               free_found_in = 1'b1;
               free_in       = idx_ff;
            end
            if (idx_last) begin
               state_in = S_STORE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_STORE: begin
            if (!free_found_ff) begin
               status_in = STAT_FULL;
               slot_in   = '0;
            end else if (dup_ff) begin
               status_in = STAT_DUP;
               slot_in   = 6'(free_ff);
            end else begin
               slot_in                   = 6'(free_ff);
               valid_in[free_ff]         = 1'b1;
               entry_in[free_ff].kind     = item_ff.kind;
               entry_in[free_ff].one_shot = item_ff.one_shot;
               entry_in[free_ff].payload  = item_ff.payload;
               entry_in[free_ff].wday     = item_ff.wday;
               entry_in[free_ff].month    = item_ff.month_num;
               entry_in[free_ff].hour     = item_ff.hour_num;
               entry_in[free_ff].minute   = item_ff.minute_num;
               entry_in[free_ff].second   = item_ff.second_num;
            end
            if (item_ff.action == ACT_ADD_RUN) begin
               idx_in   = free_found_ff ? free_ff : '0;
               state_in = S_SCAN;
            end else begin
               state_in = S_ACK;
            end
         end
         S_SCAN: begin
            if (valid_ff[idx_ff] && hit) begin
               // hold the slot until the output register can take the transfer
               if (out_free) begin
                  rsp_valid_in               = 1'b1;
                  rsp_data_in.result_kind    = RES_FIRED;
                  rsp_data_in.status         = STAT_DONE;
                  rsp_data_in.slot           = 6'(idx_ff);
                  rsp_data_in.fired_payload  = cur.payload;
                  rsp_data_in.last           = 1'b0;
                  entry_in[idx_ff]           = adv;
                  if (cur.one_shot) begin
                     valid_in[idx_ff] = 1'b0;
                  end
                  if (idx_last) begin
                     state_in = S_ACK;
                  end else begin
                     idx_in = idx_ff + IDX_W'(1);
                  end
               end
            end else if (idx_last) begin
               state_in = S_ACK;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_REMOVE: begin
            if (valid_ff[idx_ff] && cur.payload == item_ff.payload) begin
               valid_in[idx_ff] = 1'b0;
            end
            if (idx_last) begin
               state_in = S_ACK;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_ACK: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.result_kind   = RES_ACK;
               rsp_data_in.status        = status_ff;
               rsp_data_in.slot          = slot_ff;
               rsp_data_in.fired_payload = '0;
               rsp_data_in.last          = 1'b1;
               state_in                  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      free_ff       <= free_in;
      free_found_ff <= free_found_in;
      dup_ff        <= dup_in;
      status_ff     <= status_in;
      slot_ff       <= slot_in;
      item_ff       <= item_in;
      entry_ff      <= entry_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
